/* sv/bms_pkg.sv */
package bms_pkg;

   // note memory geometry: tone bytes sit at even, duration bytes at odd addresses
   localparam int NOTE_DEPTH = 256;
   localparam int NOTE_AW    = $clog2(NOTE_DEPTH);
   localparam int NOTE_IW    = NOTE_AW - 1;
   localparam int NOTE_HALF  = NOTE_DEPTH / 2;

   localparam int TONE_COUNT = 43;

   localparam logic [4:0] ALERT_SILENT = 5'd10;
   localparam logic [4:0] ALERT_AGAIN  = 5'd20;
   localparam logic [4:0] ALERT_END    = 5'd30;
   localparam logic [5:0] BINGO_SECOND = 6'd6;
   localparam logic [5:0] BINGO_END    = 6'd36;

   localparam logic [15:0] RESET_PERIOD = 16'd11059;
   localparam logic [14:0] RESET_HIGH   = 15'd5529;

   typedef enum logic [2:0] {
      FN_TICK  = 3'd0,
      FN_LOAD  = 3'd1,
      FN_PLAY  = 3'd2,
      FN_STOP  = 3'd3,
      FN_ALERT = 3'd4,
      FN_BINGO = 3'd5
   } func_type;

   typedef enum logic [2:0] {
      CSR_MUTE_TONE   = 3'd0,
      CSR_FINISH_CODE = 3'd1,
      CSR_ALERT_TONE  = 3'd2,
      CSR_BINGO_FIRST = 3'd3,
      CSR_BINGO_SECND = 3'd4
   } csr_type;

   typedef struct packed {
      logic [15:0] period;
      logic [14:0] high;
      logic        enable;
   } tone_type;

   typedef struct packed {
      logic               en;
      logic [NOTE_AW-1:0] addr;
      logic [7:0]         data;
   } note_wr_type;

   typedef struct packed {
      logic [7:0] tone;
      logic [7:0] dur;
   } note_rd_type;

   function automatic logic [15:0] tone_period(input logic [7:0] idx);
      logic [15:0] p;
      case (idx)
         8'd0:  p = 16'd21145;
         8'd1:  p = 16'd19962;
         8'd2:  p = 16'd18840;
         8'd3:  p = 16'd17780;
         8'd4:  p = 16'd16781;
         8'd5:  p = 16'd15844;
         8'd6:  p = 16'd14945;
         8'd7:  p = 16'd14106;
         8'd8:  p = 16'd13308;
         8'd9:  p = 16'd12567;
         8'd10: p = 16'd11866;
         8'd11: p = 16'd11193;
         8'd12: p = 16'd42210;
         8'd13: p = 16'd39924;
         8'd14: p = 16'd37616;
         8'd15: p = 16'd35559;
         8'd16: p = 16'd33512;
         8'd17: p = 16'd31688;
         8'd18: p = 16'd29889;
         8'd19: p = 16'd28212;
         8'd20: p = 16'd26648;
         8'd21: p = 16'd25134;
         8'd22: p = 16'd23732;
         8'd23: p = 16'd22387;
         8'd24: p = 16'd10573;
         8'd25: p = 16'd9972;
         8'd26: p = 16'd9412;
         8'd27: p = 16'd8883;
         8'd28: p = 16'd8391;
         8'd29: p = 16'd7916;
         8'd30: p = 16'd7472;
         8'd31: p = 16'd7053;
         8'd32: p = 16'd6658;
         8'd33: p = 16'd6284;
         8'd34: p = 16'd5930;
         8'd35: p = 16'd5597;
         8'd41: p = 16'd11059;
         8'd42: p = 16'd65534;
         default: p = 16'd0;
      endcase
      return p;
   endfunction

   function automatic tone_type tone_set(input logic [7:0] idx, input logic [7:0] mute);
      tone_type t;
      t.period = tone_period(idx);
      t.high   = t.period[15:1];
      t.enable = (idx != mute);
      return t;
   endfunction

endpackage

/* sv/bms_note_mem.sv */
module bms_note_mem
   import bms_pkg::*;
(
   input  logic               clock,
   input  note_wr_type        wr,
   input  logic [NOTE_IW-1:0] rd_index,
   output note_rd_type        rd
);

   logic [7:0] even_bank [NOTE_HALF];
   logic [7:0] odd_bank  [NOTE_HALF];

   logic [NOTE_IW-1:0] wr_index;
   logic               wr_even;
   logic               wr_odd;

   assign wr_index = wr.addr[NOTE_AW-1:1];
   assign wr_even  = wr.en && !wr.addr[0];
   assign wr_odd   = wr.en &&  wr.addr[0];

   always_ff @(posedge clock) begin
      if (wr_even) begin
         even_bank[wr_index] <= wr.data;
      end
      if (wr_odd) begin
         odd_bank[wr_index] <= wr.data;
      end
   end

   // registered read, a same-cycle write to the read row is passed through
   always_ff @(posedge clock) begin
      if (wr_even && (wr_index == rd_index)) begin
         rd.tone <= wr.data;
      end else begin
         rd.tone <= even_bank[rd_index];
      end
      if (wr_odd && (wr_index == rd_index)) begin
         rd.dur <= wr.data;
      end else begin
         rd.dur <= odd_bank[rd_index];
      end
   end

endmodule

/* sv/buzzer_melody_sequencer.sv */
// tick-driven buzzer tone sequencer
// req channel: one item per command; req_tuser carries the command code
// (tick, load note byte, play, stop, start alert, start score cue) and
// req_tdata carries the note address and byte used by load items
// rsp channel: exactly one item per accepted req item, holding the pwm
// period, the high count, the output enable and the player status as they
// stand after the command
// csr port: five 8-bit registers (mute tone, finish code, alert tone, two
// score cue tones); the user writes them only while no item is in flight, not enforced
// latency: the rsp item is valid in the cycle after the req item is taken
// throughput: one item per cycle unless rsp is held; the note memory is split
// into an even bank (tone bytes) and an odd bank (duration bytes) read in
// parallel and always addressed by the next play position, so a tick finds
// its note pair already in the read register
// reset: cues and player stop, play position 0, period 11059, high 5529,
// output disabled, registers back to defaults; note memory keeps its content
// stall: while rsp is held by the receiver, req_tready is low and no sequencer
// state changes; a waiting rsp item is replaced in the same cycle it is taken
module buzzer_melody_sequencer
   import bms_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // req channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // note_addr[7:0], note_byte[15:8]
   input  logic [2:0]  req_tuser,  // func[2:0]
   // rsp channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // pwm_period[15:0], pwm_high[30:16], pwm_enable[31],
                                   // playing[32], zero fill[39:33]
   // csr write port
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   // configuration registers
   logic [7:0] mute_ff;
   logic [7:0] finish_ff;
   logic [7:0] alert_tone_ff;
   logic [7:0] bingo_first_ff;
   logic [7:0] bingo_second_ff;

   // sequencer state
   logic [NOTE_IW-1:0] pos_ff, pos_in;
   logic [8:0]         note_ticks_ff, note_ticks_in;
   logic [4:0]         alert_ticks_ff, alert_ticks_in;
   logic [5:0]         bingo_ticks_ff, bingo_ticks_in;
   logic               alert_on_ff, alert_on_in;
   logic               bingo_on_ff, bingo_on_in;
   logic               player_on_ff, player_on_in;
   tone_type           tone_ff, tone_in;

   // result register
   logic     rsp_valid_ff, rsp_valid_in;
   tone_type rsp_tone_ff;
   logic     rsp_playing_ff;

   logic        req_acc;
   func_type    func;
   logic [8:0]  note_ticks_inc;
   note_wr_type note_wr;
   note_rd_type note_rd;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_acc    = req_tvalid && req_tready;
   assign func       = func_type'(req_tuser);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_playing_ff, rsp_tone_ff.enable, rsp_tone_ff.high,
                        rsp_tone_ff.period};

   // load items write the memory in the cycle they are taken
   assign note_wr.en   = req_acc && (func == FN_LOAD);
   assign note_wr.addr = NOTE_AW'(req_tdata[7:0]);
   assign note_wr.data = req_tdata[15:8];

   // the read row follows the next play position, so the pair is ready in the
   // following cycle whatever the command sequence
   bms_note_mem u_note_mem (
      .clock    (clock),
      .wr       (note_wr),
      .rd_index (pos_in),
      .rd       (note_rd)
   );

   assign note_ticks_inc = note_ticks_ff + 9'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mute_ff         <= 8'd36;
         finish_ff       <= 8'd255;
         alert_tone_ff   <= 8'd42;
         bingo_first_ff  <= 8'd11;
         bingo_second_ff <= 8'd28;
      end else if (csr_we) begin
         unique case (csr_type'(csr_index))
            CSR_MUTE_TONE:   mute_ff         <= csr_wdata;
            CSR_FINISH_CODE: finish_ff       <= csr_wdata;
            CSR_ALERT_TONE:  alert_tone_ff   <= csr_wdata;
            CSR_BINGO_FIRST: bingo_first_ff  <= csr_wdata;
            CSR_BINGO_SECND: bingo_second_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // command execution; later tone writes override earlier ones
   always_comb begin
      pos_in         = pos_ff;
      note_ticks_in  = note_ticks_ff;
      alert_ticks_in = alert_ticks_ff;
      bingo_ticks_in = bingo_ticks_ff;
      alert_on_in    = alert_on_ff;
      bingo_on_in    = bingo_on_ff;
      player_on_in   = player_on_ff;
      tone_in        = tone_ff;
      if (req_acc) begin
         unique case (func)
            FN_TICK: begin
               // alert cue
               if (alert_on_ff) begin
                  if ((alert_ticks_ff == 5'd0) || (alert_ticks_ff == ALERT_AGAIN)) begin
                     tone_in = tone_set(alert_tone_ff, mute_ff);
                  end
                  if (alert_ticks_ff == ALERT_SILENT) begin
                     tone_in.enable = 1'b0;
                  end
                  if (alert_ticks_ff >= ALERT_END) begin
                     tone_in.enable = 1'b0;
                     alert_ticks_in = 5'd0;
                     alert_on_in    = 1'b0;
                  end else begin
                     alert_ticks_in = alert_ticks_ff + 5'd1;
                  end
               end
               // score cue
               if (bingo_on_ff) begin
                  if (bingo_ticks_ff == 6'd0) begin
                     tone_in = tone_set(bingo_first_ff, mute_ff);
                  end
                  if (bingo_ticks_ff == BINGO_SECOND) begin
                     tone_in = tone_set(bingo_second_ff, mute_ff);
                  end
                  if (bingo_ticks_ff >= BINGO_END) begin
                     tone_in.enable = 1'b0;
                     bingo_ticks_in = 6'd0;
                     bingo_on_in    = 1'b0;
                  end else begin
                     bingo_ticks_in = bingo_ticks_ff + 6'd1;
                  end
               end
               // melody player only when both cues are idle after this tick
               if (!alert_on_in && !bingo_on_in && player_on_ff) begin
                  if (note_rd.tone == finish_ff) begin
                     player_on_in   = 1'b0;
                     pos_in         = '0;
                     tone_in.enable = 1'b0;
                  end else begin
                     if (note_ticks_ff == 9'd0) begin
                        tone_in = tone_set(note_rd.tone, mute_ff);
                     end
                     if (note_ticks_inc > {1'b0, note_rd.dur}) begin
                        pos_in        = pos_ff + NOTE_IW'(1);
                        note_ticks_in = 9'd0;
                     end else begin
                        note_ticks_in = note_ticks_inc;
                     end
                  end
               end
            end
            FN_LOAD: ;
            FN_PLAY: begin
               pos_in        = '0;
               note_ticks_in = 9'd0;
               player_on_in  = 1'b1;
            end
            FN_STOP: begin
               player_on_in   = 1'b0;
               pos_in         = '0;
               tone_in.enable = 1'b0;
            end
            FN_ALERT: alert_on_in = 1'b1;
            FN_BINGO: bingo_on_in = 1'b1;
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_acc) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         note_ticks_ff  <= 9'd0;
         alert_ticks_ff <= 5'd0;
         bingo_ticks_ff <= 6'd0;
         alert_on_ff    <= 1'b0;
         bingo_on_ff    <= 1'b0;
         player_on_ff   <= 1'b0;
         tone_ff        <= '{period: RESET_PERIOD, high: RESET_HIGH, enable: 1'b0};
         rsp_valid_ff   <= 1'b0;
      end else begin
         pos_ff         <= pos_in;
         note_ticks_ff  <= note_ticks_in;
         alert_ticks_ff <= alert_ticks_in;
         bingo_ticks_ff <= bingo_ticks_in;
         alert_on_ff    <= alert_on_in;
         bingo_on_ff    <= bingo_on_in;
         player_on_ff   <= player_on_in;
         tone_ff        <= tone_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // result payload, loaded with the state as it stands after the item
   always_ff @(posedge clock) begin
      if (req_acc) begin
         rsp_tone_ff    <= tone_in;
         rsp_playing_ff <= player_on_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_pos_hold: assert property (@(posedge clock) disable iff (reset)
      !req_acc |=> $stable(pos_ff))
      else $error("play position moved without an item");

   a_alert_cnt: assert property (@(posedge clock) disable iff (reset)
      (alert_ticks_ff != 5'd0) |-> alert_on_ff)
      else $error("alert count running while alert cue is off");

   a_bingo_cnt: assert property (@(posedge clock) disable iff (reset)
      (bingo_ticks_ff != 6'd0) |-> bingo_on_ff)
      else $error("score cue count running while score cue is off");

   a_stop: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (func == FN_STOP)) |=> (!player_on_ff && (pos_ff == '0) && !tone_ff.enable))
      else $error("stop did not halt the player");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (rsp_tvalid && (rsp_tdata[32] == player_on_ff)))
      else $error("accepted item produced no matching result");
`endif

endmodule
